>>> rtl/sir_group_compartment_update_core_defines.svh
// Assertion macros shared by the SIR group update RTL
`ifndef SIR_GROUP_COMPARTMENT_UPDATE_CORE_DEFINES_SVH
`define SIR_GROUP_COMPARTMENT_UPDATE_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define SGCU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SGCU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/sgcu_pkg.sv
// Package: types, constants and helpers for the SIR group update block
package sgcu_pkg;
    localparam int POPULATION = 4096;
    localparam int MAX_GROUPS = 4096;
    localparam int PW = $clog2(POPULATION);
    localparam int GW = $clog2(MAX_GROUPS);
    localparam int CW = 13;
    localparam int RW = 56;
    localparam int RECW = 44;
    localparam int GAINW = 32;
    localparam int NCFG = 4;
    localparam int CFGIW = 2;

    localparam logic [CFGIW-1:0] CFG_COMM = 2'd0;
    localparam logic [CFGIW-1:0] CFG_WORK = 2'd1;
    localparam logic [CFGIW-1:0] CFG_FAM = 2'd2;
    localparam logic [CFGIW-1:0] CFG_REC = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [1:0] CMP_S = 2'd0;
    localparam logic [1:0] CMP_I = 2'd1;
    localparam logic [1:0] CMP_R = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_UPDATE, ST_OUT
    } state_t;

    typedef struct packed {
        logic [CW-1:0] s;
        logic [CW-1:0] i;
        logic [CW-1:0] r;
    } counts_t;

    // Controller commands
    typedef struct packed {
        logic capture;   // latch input item
        logic read;      // resolve groups and step
        logic mul1;      // read group count stores
        logic mul2;      // products S*I
        logic update;    // gain multiplies, write back counts and rates
        logic out_load;  // load output register
    } cmd_t;

    // Datapath status
    typedef struct packed {
        logic clear_busy;
    } sts_t;
endpackage

>>> rtl/sgcu_ctrl.sv
// Controller state machine for the SIR group update block
module sgcu_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  sgcu_pkg::sts_t sts,
    output sgcu_pkg::cmd_t cmd
);
    import sgcu_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid && s_ready) state_next = ST_READ;
            ST_READ:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        s_ready = (state_reg == ST_IDLE) && !sts.clear_busy;
        cmd.capture = s_valid && s_ready;
        cmd.read = (state_reg == ST_READ);
        cmd.mul1 = (state_reg == ST_MUL1);
        cmd.mul2 = (state_reg == ST_MUL2);
        cmd.update = (state_reg == ST_UPDATE);
        cmd.out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.out_load) m_valid_next = 1'b1;
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`include "sir_group_compartment_update_core_defines.svh"
    `SGCU_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
    `SGCU_ASSERT_NEXT(a_accept_read, aclk, aresetn, s_valid && s_ready, state_reg == ST_READ)
    `SGCU_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.out_load, m_valid_reg)
endmodule

>>> rtl/sgcu_dp.sv
// Datapath: person and group stores, count and rate arithmetic
module sgcu_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sgcu_pkg::cmd_t                 cmd,
    output sgcu_pkg::sts_t                 sts,
    input  logic                           cfg_we,
    input  logic [sgcu_pkg::CFGIW-1:0]     cfg_index,
    input  logic [sgcu_pkg::GAINW-1:0]     cfg_data,
    input  logic                           s_op,
    input  logic [11:0]                    s_person,
    input  logic [11:0]                    s_work_group,
    input  logic [11:0]                    s_family_group,
    output logic [sgcu_pkg::RW-1:0]        m_infection_rate,
    output logic [sgcu_pkg::RECW-1:0]      m_recovery_rate,
    output logic [sgcu_pkg::CW-1:0]        m_susceptible_total,
    output logic [sgcu_pkg::CW-1:0]        m_infected_total,
    output logic [sgcu_pkg::CW-1:0]        m_recovered_total,
    output logic                           m_status
);
    import sgcu_pkg::*;

    // Gain registers
    logic [GAINW-1:0] gain_reg [NCFG];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[CFG_COMM] <= 32'd6291;
            gain_reg[CFG_WORK] <= 32'd1342177;
            gain_reg[CFG_FAM] <= 32'd16777216;
            gain_reg[CFG_REC] <= 32'd19293798;
        end else if (cfg_we) begin
            gain_reg[cfg_index] <= cfg_data;
        end
    end

    // Memories
    logic [1:0]      pcmp_mem [POPULATION];
    logic [GW-1:0]   pwg_mem  [POPULATION];
    logic [GW-1:0]   pfg_mem  [POPULATION];
    counts_t         wcnt_mem [MAX_GROUPS];
    counts_t         fcnt_mem [MAX_GROUPS];

    // Clearing pass over group counts after reset
    logic [GW:0] clr_reg;
    logic        clr_busy;
    assign clr_busy = !clr_reg[GW];
    assign sts.clear_busy = clr_busy;
    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (clr_busy) clr_reg <= clr_reg + 1'b1;
    end

    // Captured item
    logic          op_reg, bad_reg;
    logic [PW-1:0] who_reg;
    logic [GW-1:0] lwg_reg, lfg_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_op;
            who_reg <= s_person[PW-1:0];
            bad_reg <= 1'b0;
            lwg_reg <= s_work_group[GW-1:0];
            lfg_reg <= s_family_group[GW-1:0];
        end
    end

    // Person store read (registered)
    logic [1:0]    pc_rd;
    logic [GW-1:0] pwg_rd, pfg_rd;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pc_rd <= pcmp_mem[s_person[PW-1:0]];
            pwg_rd <= pwg_mem[s_person[PW-1:0]];
            pfg_rd <= pfg_mem[s_person[PW-1:0]];
        end
    end

    // Resolve groups and step in READ
    logic [GW-1:0] wg_reg, fg_reg;
    logic [1:0]    from_reg;
    logic          rej_reg;
    counts_t       wc_rd, fc_rd;
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            wg_reg <= (op_reg == OP_LOAD) ? lwg_reg : pwg_rd;
            fg_reg <= (op_reg == OP_LOAD) ? lfg_reg : pfg_rd;
            from_reg <= pc_rd;
            rej_reg <= bad_reg || (op_reg == OP_ADVANCE && pc_rd >= CMP_R);
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            wc_rd <= wcnt_mem[wg_reg];
            fc_rd <= fcnt_mem[fg_reg];
        end
    end

    counts_t cc_reg;
    logic [RW-1:0] rate_reg [3];

    // New counts
    function automatic counts_t step_cnt(counts_t c, logic op, logic [1:0] from);
        counts_t n;
        n = c;
        if (op == OP_LOAD) n.s = c.s + 1'b1;
        else if (from == CMP_S) begin
            n.s = c.s - 1'b1; n.i = c.i + 1'b1;
        end else begin
            n.i = c.i - 1'b1; n.r = c.r + 1'b1;
        end
        return n;
    endfunction

    counts_t wc_new, fc_new, cc_new;
    assign wc_new = step_cnt(wc_rd, op_reg, from_reg);
    assign fc_new = step_cnt(fc_rd, op_reg, from_reg);
    assign cc_new = step_cnt(cc_reg, op_reg, from_reg);

    // S*I products, old and new, per context
    logic [2*CW-1:0] po_reg [3];
    logic [2*CW-1:0] pn_reg [3];
    always_ff @(posedge aclk) begin
        if (cmd.mul2) begin
            po_reg[0] <= cc_reg.s * cc_reg.i;
            pn_reg[0] <= cc_new.s * cc_new.i;
            po_reg[1] <= wc_rd.s * wc_rd.i;
            pn_reg[1] <= wc_new.s * wc_new.i;
            po_reg[2] <= fc_rd.s * fc_rd.i;
            pn_reg[2] <= fc_new.s * fc_new.i;
        end
    end

    // Gain multiply and rate update
    logic [RW-1:0] tn [3];
    logic [RW-1:0] to [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tn[k] = RW'(gain_reg[k] * pn_reg[k]);
            to[k] = RW'(gain_reg[k] * po_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= '0;
            for (int k = 0; k < 3; k++) rate_reg[k] <= '0;
        end else if (cmd.update && !rej_reg) begin
            cc_reg <= cc_new;
            for (int k = 0; k < 3; k++) rate_reg[k] <= rate_reg[k] - to[k] + tn[k];
        end
    end

    // Memory writes
    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            wcnt_mem[clr_reg[GW-1:0]] <= '0;
            fcnt_mem[clr_reg[GW-1:0]] <= '0;
        end else if (cmd.update && !rej_reg) begin
            wcnt_mem[wg_reg] <= wc_new;
            fcnt_mem[fg_reg] <= fc_new;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.update && !rej_reg) begin
            pcmp_mem[who_reg] <= (op_reg == OP_LOAD) ? CMP_S : (from_reg + 2'd1);
            if (op_reg == OP_LOAD) begin
                pwg_mem[who_reg] <= wg_reg;
                pfg_mem[who_reg] <= fg_reg;
            end
        end
    end

    // Output register
    logic [RW-1:0] rsum;
    assign rsum = rate_reg[0] + rate_reg[1] + rate_reg[2];
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_infection_rate <= rsum;
            m_recovery_rate <= RECW'(gain_reg[CFG_REC] * cc_reg.i);
            m_susceptible_total <= cc_reg.s;
            m_infected_total <= cc_reg.i;
            m_recovered_total <= cc_reg.r;
            m_status <= rej_reg;
        end
    end

`include "sir_group_compartment_update_core_defines.svh"
    `SGCU_ASSERT_IMPL(a_no_work_clear, aclk, aresetn, clr_busy, !cmd.capture)
    `SGCU_ASSERT_NEXT(a_rej_hold, aclk, aresetn, cmd.update && rej_reg, $stable(cc_reg))
    `SGCU_ASSERT_IMPL(a_one_cmd, aclk, aresetn, 1'b1, $onehot0({cmd.read, cmd.mul1, cmd.mul2, cmd.update}))
endmodule

>>> rtl/sir_group_compartment_update_core.sv
// Top level: SIR group compartment update core
// Each item passes through the sequencer states in order: accept, read, count read, S*I multiply,
// gain update, output; no new item is taken until the sequencer is back in idle, and
// the output step waits while an earlier result is still held by the receiver.
// Reset: synchronous active-low; group counts cleared by a pass over all 4096 groups after
// reset, during which no input item is taken. Gains return to defaults.
module sir_group_compartment_update_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [11:0] s_person,
    input  logic [11:0] s_work_group,
    input  logic [11:0] s_family_group,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [55:0] m_infection_rate,
    output logic [43:0] m_recovery_rate,
    output logic [12:0] m_susceptible_total,
    output logic [12:0] m_infected_total,
    output logic [12:0] m_recovered_total,
    output logic        m_status
);
    import sgcu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sgcu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    sgcu_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_op(s_op), .s_person(s_person), .s_work_group(s_work_group),
        .s_family_group(s_family_group),
        .m_infection_rate(m_infection_rate), .m_recovery_rate(m_recovery_rate),
        .m_susceptible_total(m_susceptible_total), .m_infected_total(m_infected_total),
        .m_recovered_total(m_recovered_total), .m_status(m_status)
    );
endmodule

>>> tb/tb_sir_group_compartment_update_core.sv
// Testbench for the SIR group compartment update core: random and directed items, scoreboard
`timescale 1ns / 100ps

module tb_sir_group_compartment_update_core;
    import sgcu_pkg::*;

    typedef struct {
        logic [55:0] infection_rate;
        logic [43:0] recovery_rate;
        logic [12:0] s_total;
        logic [12:0] i_total;
        logic [12:0] r_total;
        logic        status;
    } sir_result_t;

    // Scoreboard with its own copy of the SIR bookkeeping
    class sir_scoreboard;
        bit [1:0]    compartment[POPULATION];
        bit [11:0]   work_of[POPULATION];
        bit [11:0]   family_of[POPULATION];
        counts_t     work_cnt[MAX_GROUPS];
        counts_t     family_cnt[MAX_GROUPS];
        counts_t     comm_cnt;
        bit [55:0]   ctx_rate[3];
        bit [31:0]   gain[NCFG];
        sir_result_t expected_q[$];
        int          failures;

        function new();
            foreach (work_cnt[g]) begin
                work_cnt[g] = '0;
                family_cnt[g] = '0;
            end
            comm_cnt = '0;
            foreach (ctx_rate[k]) ctx_rate[k] = '0;
            gain[CFG_COMM] = 32'd6291;
            gain[CFG_WORK] = 32'd1342177;
            gain[CFG_FAM]  = 32'd16777216;
            gain[CFG_REC]  = 32'd19293798;
            failures = 0;
        endfunction

        function void set_gain(logic [1:0] idx, logic [31:0] value);
            gain[idx] = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit [55:0] si_term(counts_t c, bit [31:0] g);
            bit [63:0] p;
            p = 64'(g) * 64'(c.s) * 64'(c.i);
            return p[55:0];
        endfunction

        function void bump(inout counts_t c, input bit [1:0] k, input bit up);
            bit [12:0] d;
            d = up ? 13'd1 : 13'h1FFF;
            case (k)
                CMP_S:   c.s = c.s + d;
                CMP_I:   c.i = c.i + d;
                default: c.r = c.r + d;
            endcase
        endfunction

        // One group moves a person from one compartment to another (or just adds one)
        function void move(inout counts_t c, inout bit [55:0] r, input bit has_from,
                           input bit [1:0] from, input bit [1:0] to, input bit [31:0] g);
            r = r - si_term(c, g);
            if (has_from) bump(c, from, 1'b0);
            bump(c, to, 1'b1);
            r = r + si_term(c, g);
        endfunction

        function void note_input(logic op, logic [11:0] who, logic [11:0] wg,
                                 logic [11:0] fg);
            sir_result_t e;
            bit [1:0]    from;
            bit [63:0]   rec;
            e.status = 1'b0;
            if (op == OP_LOAD) begin
                compartment[who] = CMP_S;
                work_of[who] = wg;
                family_of[who] = fg;
                move(comm_cnt, ctx_rate[0], 1'b0, CMP_S, CMP_S, gain[CFG_COMM]);
                move(work_cnt[wg], ctx_rate[1], 1'b0, CMP_S, CMP_S, gain[CFG_WORK]);
                move(family_cnt[fg], ctx_rate[2], 1'b0, CMP_S, CMP_S, gain[CFG_FAM]);
            end else begin
                from = compartment[who];
                if (from == CMP_R) begin
                    e.status = 1'b1;
                end else begin
                    move(comm_cnt, ctx_rate[0], 1'b1, from, from + 2'd1, gain[CFG_COMM]);
                    move(work_cnt[work_of[who]], ctx_rate[1], 1'b1, from, from + 2'd1,
                         gain[CFG_WORK]);
                    move(family_cnt[family_of[who]], ctx_rate[2], 1'b1, from, from + 2'd1,
                         gain[CFG_FAM]);
                    compartment[who] = from + 2'd1;
                end
            end
            rec = 64'(gain[CFG_REC]) * 64'(comm_cnt.i);
            e.infection_rate = ctx_rate[0] + ctx_rate[1] + ctx_rate[2];
            e.recovery_rate = rec[43:0];
            e.s_total = comm_cnt.s;
            e.i_total = comm_cnt.i;
            e.r_total = comm_cnt.r;
            expected_q.push_back(e);
        endfunction

        function void check_result(sir_result_t a);
            sir_result_t e;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result transfer at %0t", $realtime);
                return;
            end
            e = expected_q.pop_front();
            if (a.infection_rate !== e.infection_rate || a.recovery_rate !== e.recovery_rate ||
                a.s_total !== e.s_total || a.i_total !== e.i_total ||
                a.r_total !== e.r_total || a.status !== e.status) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch at %0t: exp inf=%h rec=%h S=%0d I=%0d R=%0d st=%b | act inf=%h rec=%h S=%0d I=%0d R=%0d st=%b",
                             $realtime, e.infection_rate, e.recovery_rate, e.s_total,
                             e.i_total, e.r_total, e.status, a.infection_rate,
                             a.recovery_rate, a.s_total, a.i_total, a.r_total, a.status);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_COMM;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_LOAD;
    logic [11:0] s_person = '0;
    logic [11:0] s_work_group = '0;
    logic [11:0] s_family_group = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [55:0] m_infection_rate;
    logic [43:0] m_recovery_rate;
    logic [12:0] m_susceptible_total;
    logic [12:0] m_infected_total;
    logic [12:0] m_recovered_total;
    logic        m_status;

    sir_scoreboard sb = new();
    bit  loaded[POPULATION];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  quiet_cycles = 0;

    sir_group_compartment_update_core u_top (.*);

    always #10 aclk = ~aclk;

    // Result side: random stalls, check every transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_infection_rate, m_recovery_rate, m_susceptible_total,
                              m_infected_total, m_recovered_total, m_status});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: cycles without any transfer (covers the clearing pass after reset)
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [11:0] who, logic [11:0] wg, logic [11:0] fg);
        if (s_valid && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_person <= who;
        s_work_group <= wg;
        s_family_group <= fg;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, who, wg, fg);
        if (op == OP_LOAD) loaded[who] = 1'b1;
    endtask

    // Drop valid, then let every outstanding result drain
    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_gains(logic [31:0] g0, logic [31:0] g1, logic [31:0] g2,
                               logic [31:0] g3);
        logic [31:0] v[4];
        v = '{g0, g1, g2, g3};
        for (int k = 0; k < NCFG; k++) begin
            cfg_we <= 1'b1;
            cfg_index <= k[1:0];
            cfg_data <= v[k];
            @(posedge aclk);
            sb.set_gain(k[1:0], v[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // Random item: mostly loads and advances of known people in crowded groups
    task automatic random_item();
        logic [11:0] who, wg, fg;
        int          roll;
        roll = $urandom_range(99);
        who = (roll < 10) ? 12'($urandom) : 12'($urandom_range(0, 200));
        if (roll < 20) begin
            wg = 12'($urandom);
            fg = 12'($urandom);
        end else begin
            wg = 12'($urandom_range(0, 5));
            fg = 12'($urandom_range(4090, 4095));
        end
        if (!loaded[who] || $urandom_range(99) < 40) send_item(OP_LOAD, who, wg, fg);
        else send_item(OP_ADVANCE, who, 12'($urandom), 12'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, full S-I-R path, rejection, reload
        send_item(OP_LOAD, 12'd0, 12'd0, 12'd0);
        send_item(OP_LOAD, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(OP_LOAD, 12'd1, 12'd0, 12'hFFF);
        send_item(OP_LOAD, 12'hAAA, 12'h555, 12'hAAA);
        send_item(OP_LOAD, 12'h555, 12'hAAA, 12'h555);
        send_item(OP_ADVANCE, 12'd0, 12'hFFF, 12'hFFF);
        send_item(OP_ADVANCE, 12'hFFF, 12'd0, 12'd0);
        send_item(OP_ADVANCE, 12'd1, 12'd0, 12'd0);
        send_item(OP_ADVANCE, 12'd0, 12'd0, 12'd0);
        send_item(OP_ADVANCE, 12'd0, 12'd0, 12'd0);   // recovered: rejected
        send_item(OP_LOAD, 12'd0, 12'd7, 12'd7);      // reload counts again
        send_item(OP_ADVANCE, 12'hAAA, 12'd0, 12'd0);
        send_item(OP_ADVANCE, 12'h555, 12'd0, 12'd0);
        send_item(OP_ADVANCE, 12'hFFF, 12'd0, 12'd0);
        send_item(OP_ADVANCE, 12'hFFF, 12'd0, 12'd0); // rejected
        drain();

        // Random phases, each under a new gain setting
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_gains('1, '1, '1, '1);
                1: write_gains('0, '0, '0, '0);
                default: write_gains($urandom, $urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < 130; n++) begin
                case ((ph * 130 + n) * 3 / 650)
                    0: begin send_idle_pct = 15; recv_stall_pct = 66; end
                    1: begin send_idle_pct = 66; recv_stall_pct = 15; end
                    default: begin send_idle_pct = 0; recv_stall_pct = 0; end
                endcase
                random_item();
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
